/* rtl/bldc_forced_drag_commutator_defines.svh */
// Assertion macros used by the checker file of the forced drag commutator.
// Depends on nothing; include by bare file name.
`ifndef BLDC_FORCED_DRAG_COMMUTATOR_DEFINES_SVH
`define BLDC_FORCED_DRAG_COMMUTATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BFDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bfdc_pkg.sv */
// Package for the forced drag commutator: field widths, opcodes, register
// indexes, reset values and the six-step commutation table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfdc_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned W16       = 16;
  localparam int unsigned W8        = 8;
  localparam int unsigned GATE_W    = 6;
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ACC_W     = 20;  // 3*65535 + 7*65535 fits in 20 bits
  localparam int unsigned RECIP_W   = 20;
  localparam int unsigned PROD_W    = ACC_W + RECIP_W;
  localparam int unsigned RECIP_SH  = 23;  // floor(x/10) = (x*838861) >> 23 for x < 2^22

  localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD  = 3'd0,
    CFG_START_PERIOD = 3'd1,
    CFG_FLOOR_PERIOD = 3'd2,
    CFG_PERIOD_STEP  = 3'd3,
    CFG_UPPER_THRESH = 3'd4,
    CFG_LOWER_THRESH = 3'd5,
    CFG_DEMAG_OFFSET = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_t;

  // Register reset values
  localparam logic [W16-1:0]        RST_TICK_PERIOD  = 16'd50;
  localparam logic [W16-1:0]        RST_START_PERIOD = 16'd6000;
  localparam logic [W16-1:0]        RST_FLOOR_PERIOD = 16'd5000;
  localparam logic [W8-1:0]         RST_PERIOD_STEP  = 8'd1;
  localparam logic signed [W16-1:0] RST_UPPER_THRESH = 16'sd1000;
  localparam logic signed [W16-1:0] RST_LOWER_THRESH = -16'sd1000;
  localparam logic [W8-1:0]         RST_DEMAG_OFFSET = 8'd15;

  // Rotor alignment step: a start request commutates from it to the next step
  localparam logic [STEP_W-1:0] STEP_ALIGN = 3'd2;
  localparam logic [GATE_W-1:0] GATES_OFF  = 6'h00;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [GATE_W-1:0] gates;
  } comm_t;

  // One commutation: next step and its gate pattern; unknown steps hold
  function automatic comm_t commutate(input logic [STEP_W-1:0] step,
                                      input logic [GATE_W-1:0] gates);
    comm_t r;
    r.step  = step;
    r.gates = gates;
    unique case (step)
      3'd1:    begin r.step = 3'd2; r.gates = 6'h0A; end
      3'd2:    begin r.step = 3'd3; r.gates = 6'h0C; end
      3'd3:    begin r.step = 3'd4; r.gates = 6'h14; end
      3'd4:    begin r.step = 3'd5; r.gates = 6'h11; end
      3'd5:    begin r.step = 3'd6; r.gates = 6'h21; end
      3'd6:    begin r.step = 3'd1; r.gates = 6'h22; end
      default: begin r.step = step; r.gates = gates; end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/bfdc_if.sv */
// Channel interfaces of the forced drag commutator: event input, result
// output and register write. Depends on bfdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfdc_in_if import bfdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [W16-1:0]   sample;
  logic [W16-1:0]          elapsed_since_commutation;

  modport source (output valid, opcode, sample, elapsed_since_commutation, input ready);
  modport sink   (input valid, opcode, sample, elapsed_since_commutation, output ready);
endinterface

interface bfdc_out_if import bfdc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [GATE_W-1:0]   gate_pattern;
  logic                dragging;
  logic                commutated;
  logic [W16-1:0]      drag_period_now;
  logic [W16-1:0]      delay_reload;
  logic                delay_load;

  modport source (output valid, gate_pattern, dragging, commutated, drag_period_now,
                  delay_reload, delay_load, input ready);
  modport sink   (input valid, gate_pattern, dragging, commutated, drag_period_now,
                  delay_reload, delay_load, output ready);
endinterface

interface bfdc_cfg_if import bfdc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [W16-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/bldc_forced_drag_commutator.sv */
// Six-step sensorless BLDC start-up sequencer (open-loop forced drag).
// Takes one event request per cycle while results are taken (tick, start,
// stop, back-EMF sample) and returns one result per request: an input
// register holds the request, the state update and result are formed in one
// pass and land in the result register. The input register frees itself
// whenever the result register can move, so a new request enters every cycle
// while results are taken. The 30 degree delay path (3*old + 7*new, divide by
// ten through a 20x20 reciprocal multiply, add offset, saturate) is the
// longest path. Register writes are accepted every cycle.
// Depends on bfdc_pkg and bfdc_if.
`timescale 1ns / 1ps
`default_nettype none

module bldc_forced_drag_commutator
  import bfdc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  bfdc_in_if.sink     in_req,
  bfdc_out_if.source  out_rsp,
  bfdc_cfg_if.sink    cfg_wr
);

  // Configuration registers
  logic [W16-1:0]        tick_period_r;
  logic [W16-1:0]        start_period_r;
  logic [W16-1:0]        floor_period_r;
  logic [W8-1:0]         period_step_r;
  logic signed [W16-1:0] upper_thresh_r;
  logic signed [W16-1:0] lower_thresh_r;
  logic [W8-1:0]         demag_offset_r;

  // Block state
  logic                  drive_mode_r,     drive_mode_nxt;
  logic [STEP_W-1:0]     rotor_step_r,     rotor_step_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r,        elapsed_nxt;
  logic [W16-1:0]        drag_period_r,    drag_period_nxt;
  logic [W16-1:0]        filt_delay_r,     filt_delay_nxt;
  logic [GATE_W-1:0]     gate_state_r,     gate_state_nxt;

  // Input register
  logic                  s1_valid_r;
  logic [OP_W-1:0]       s1_opcode_r;
  logic signed [W16-1:0] s1_sample_r;
  logic [ACC_W-1:0]      s1_since7_r;

  // Result register
  logic                  out_valid_r;
  logic [GATE_W-1:0]     out_gate_r;
  logic                  out_drag_r;
  logic                  out_comm_r;
  logic [W16-1:0]        out_period_r;
  logic [W16-1:0]        out_reload_r;
  logic                  out_load_r;

  logic                  advance;
  logic                  did_comm;
  logic                  load;
  logic [W16-1:0]        reload;
  logic [W16-1:0]        period_gap;
  comm_t                 comm_drag;
  comm_t                 comm_start;
  logic [ACC_W-1:0]      delay_acc;
  logic [PROD_W-1:0]     delay_prod;
  logic [W16:0]          delay_sum;
  logic                  zero_cross;
  op_t                   op;

  // Handshake: move the held request whenever the result slot frees up
  assign advance      = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || advance;
  assign cfg_wr.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r  <= RST_TICK_PERIOD;
      start_period_r <= RST_START_PERIOD;
      floor_period_r <= RST_FLOOR_PERIOD;
      period_step_r  <= RST_PERIOD_STEP;
      upper_thresh_r <= RST_UPPER_THRESH;
      lower_thresh_r <= RST_LOWER_THRESH;
      demag_offset_r <= RST_DEMAG_OFFSET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_idx_t'(cfg_wr.index))
        CFG_TICK_PERIOD:  tick_period_r  <= cfg_wr.data;
        CFG_START_PERIOD: start_period_r <= cfg_wr.data;
        CFG_FLOOR_PERIOD: floor_period_r <= cfg_wr.data;
        CFG_PERIOD_STEP:  period_step_r  <= cfg_wr.data[W8-1:0];
        CFG_UPPER_THRESH: upper_thresh_r <= cfg_wr.data;
        CFG_LOWER_THRESH: lower_thresh_r <= cfg_wr.data;
        CFG_DEMAG_OFFSET: demag_offset_r <= cfg_wr.data[W8-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request; prescale the commutation timer reading by seven
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_opcode_r <= in_req.opcode;
      s1_sample_r <= in_req.sample;
      s1_since7_r <= {1'b0, in_req.elapsed_since_commutation, 3'b000}
                     - {4'b0000, in_req.elapsed_since_commutation};
    end
  end

  // Commutation outcomes for a drag tick and for a start
  assign comm_drag  = commutate(rotor_step_r, gate_state_r);
  assign comm_start = commutate(STEP_ALIGN, gate_state_r);
  assign period_gap = drag_period_r - floor_period_r;

  // Delay filter: floor((3*old + 7*new)/10) + offset, saturated
  assign delay_acc  = {3'b000, filt_delay_r, 1'b0} + {4'b0000, filt_delay_r} + s1_since7_r;
  assign delay_prod = delay_acc * RECIP_TEN;
  assign delay_sum  = delay_prod[PROD_W-1:RECIP_SH] + {9'd0, demag_offset_r};
  assign zero_cross = (s1_sample_r > upper_thresh_r) || (s1_sample_r < lower_thresh_r);

  assign op = op_t'(s1_opcode_r);

  // Next state and result for the held request
  always_comb begin
    drive_mode_nxt  = drive_mode_r;
    rotor_step_nxt  = rotor_step_r;
    elapsed_nxt     = elapsed_r;
    drag_period_nxt = drag_period_r;
    filt_delay_nxt  = filt_delay_r;
    gate_state_nxt  = gate_state_r;
    did_comm        = 1'b0;
    load            = 1'b0;
    reload          = '0;
    unique case (op)
      OP_TICK: begin
        if (drive_mode_r) begin
          if (elapsed_r >= {1'b0, drag_period_r}) begin
            elapsed_nxt = '0;
            if (drag_period_r <= floor_period_r) begin
              drag_period_nxt = floor_period_r;
            end else if (period_gap < {8'd0, period_step_r}) begin
              drag_period_nxt = floor_period_r;
            end else begin
              drag_period_nxt = drag_period_r - {8'd0, period_step_r};
            end
            rotor_step_nxt = comm_drag.step;
            gate_state_nxt = comm_drag.gates;
            did_comm       = 1'b1;
          end else begin
            elapsed_nxt = elapsed_r + {1'b0, tick_period_r};
          end
        end
      end
      OP_START: begin
        elapsed_nxt     = '0;
        drag_period_nxt = start_period_r;
        rotor_step_nxt  = comm_start.step;
        gate_state_nxt  = comm_start.gates;
        did_comm        = 1'b1;
        drive_mode_nxt  = 1'b1;
      end
      OP_STOP: begin
        gate_state_nxt = GATES_OFF;
        drive_mode_nxt = 1'b0;
      end
      OP_SAMPLE: begin
        if (zero_cross) begin
          reload         = delay_sum[W16] ? {W16{1'b1}} : delay_sum[W16-1:0];
          filt_delay_nxt = reload;
          load           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Commit state as the request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r  <= 1'b0;
      rotor_step_r  <= '0;
      elapsed_r     <= '0;
      drag_period_r <= '0;
      filt_delay_r  <= '0;
      gate_state_r  <= GATES_OFF;
    end else if (advance) begin
      drive_mode_r  <= drive_mode_nxt;
      rotor_step_r  <= rotor_step_nxt;
      elapsed_r     <= elapsed_nxt;
      drag_period_r <= drag_period_nxt;
      filt_delay_r  <= filt_delay_nxt;
      gate_state_r  <= gate_state_nxt;
    end
  end

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_gate_r   <= gate_state_nxt;
      out_drag_r   <= drive_mode_nxt;
      out_comm_r   <= did_comm;
      out_period_r <= drag_period_nxt;
      out_reload_r <= reload;
      out_load_r   <= load;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.gate_pattern    = out_gate_r;
  assign out_rsp.dragging        = out_drag_r;
  assign out_rsp.commutated      = out_comm_r;
  assign out_rsp.drag_period_now = out_period_r;
  assign out_rsp.delay_reload    = out_reload_r;
  assign out_rsp.delay_load      = out_load_r;

endmodule

`default_nettype wire

/* rtl/bfdc_checker.sv */
// Port-level checks for the forced drag commutator, bound to the top level.
// Depends on bfdc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "bldc_forced_drag_commutator_defines.svh"

module bfdc_checker
  import bfdc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [GATE_W-1:0] gate_pattern,
  input wire logic              dragging,
  input wire logic              commutated,
  input wire logic [W16-1:0]    delay_reload,
  input wire logic              delay_load
);

  // A stalled result stays put
  `BFDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(gate_pattern) && $stable(delay_reload), "result changed while stalled")

  // No delay value without a delay load request
  `BFDC_ASSERT_IMPL(a_reload_zero, clk, rst_n, out_valid && !delay_load, delay_reload == '0, "delay_reload set without delay_load")

  // Stopped: gates off, never a commutation
  `BFDC_ASSERT_IMPL(a_stopped_off, clk, rst_n, out_valid && !dragging, (gate_pattern == GATES_OFF) && !commutated, "gates active or commutation while stopped")

  // Dragging: exactly two switches on
  `BFDC_ASSERT_IMPL(a_drag_pair, clk, rst_n, out_valid && dragging, $countones(gate_pattern) == 2, "drag gate pattern is not a pair")

endmodule

bind bldc_forced_drag_commutator bfdc_checker u_bfdc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .gate_pattern (out_rsp.gate_pattern),
  .dragging     (out_rsp.dragging),
  .commutated   (out_rsp.commutated),
  .delay_reload (out_rsp.delay_reload),
  .delay_load   (out_rsp.delay_load)
);

`default_nettype wire
